// ===== rtl/core/apsp_pkg.sv =====
// Shared types, constants and register codes of the all-pairs shortest path block.
package apsp_pkg;

	// Sizing
	localparam int MAX_NODES  = 128;
	localparam int COST_BITS  = 16;
	localparam int DIST_BITS  = 24;
	localparam int TRIP_BITS  = DIST_BITS + 1;
	localparam int TOTAL_BITS = 48;
	localparam int NODE_BITS  = $clog2(MAX_NODES);
	localparam int CNT_BITS   = $clog2(MAX_NODES + 1);
	// Matrix address is {row, column}; depth is rounded up to a power of two
	localparam int ADDR_BITS  = 2 * NODE_BITS;
	localparam int MEM_DEPTH  = 1 << ADDR_BITS;

	// Input field widths
	localparam int NODE_IN_BITS = 7;
	localparam int EDGE_IN_BITS = 16;
	localparam int COST_USE     = (COST_BITS < EDGE_IN_BITS) ? COST_BITS : EDGE_IN_BITS;
	localparam logic [EDGE_IN_BITS-1:0] COST_MASK = EDGE_IN_BITS'((64'd1 << COST_USE) - 64'd1);

	localparam logic [DIST_BITS-1:0] DIST_INF = '1;
	localparam logic [DIST_BITS-1:0] DIST_MAX = DIST_INF - DIST_BITS'(1);

	// Configuration port
	localparam int PADDR_BITS   = 3;
	localparam int PDATA_BITS   = 32;
	localparam int REG_IDX_BITS = PADDR_BITS - 2;
	localparam logic [REG_IDX_BITS-1:0] REG_NODE_COUNT = REG_IDX_BITS'(0);
	localparam logic [REG_IDX_BITS-1:0] REG_DEPOT_NODE = REG_IDX_BITS'(1);
	localparam logic [7:0] NODE_COUNT_RESET = 8'd128;
	localparam logic [6:0] DEPOT_NODE_RESET = 7'd0;

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_EDGE    = 2'd1,
		REQ_CLOSURE = 2'd2,
		REQ_QUERY   = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [7:0] node_count;
		logic [6:0] depot_node;
	} cfg_t;

	typedef struct packed {
		req_type_t                 req_type;
		logic [NODE_IN_BITS-1:0]   node_a;
		logic [NODE_IN_BITS-1:0]   node_b;
		logic [EDGE_IN_BITS-1:0]   edge_cost;
		logic                      dir_a_to_b;
		logic                      dir_b_to_a;
	} req_t;

	typedef struct packed {
		logic [TRIP_BITS-1:0]  round_trip;
		logic [TOTAL_BITS-1:0] running_total;
		logic                  unreachable;
		logic                  done_res;
	} res_t;

endpackage

// ===== rtl/core/apsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module apsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/apsp_regs.sv =====
// Configuration register file behind the APB-style port.
module apsp_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [apsp_pkg::PADDR_BITS-1:0]  paddr,
	input  logic [apsp_pkg::PDATA_BITS-1:0]  pwdata,
	output logic [apsp_pkg::PDATA_BITS-1:0]  prdata,
	output logic                             pready,
	output apsp_pkg::cfg_t                   cfg
);
	import apsp_pkg::*;

	logic [REG_IDX_BITS-1:0] idx;
	logic                    wr_en;
	cfg_t                    cfg_q;

	assign idx    = paddr[PADDR_BITS-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Take a write transfer at the end of the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_count <= NODE_COUNT_RESET;
			cfg_q.depot_node <= DEPOT_NODE_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_NODE_COUNT: cfg_q.node_count <= pwdata[7:0];
				REG_DEPOT_NODE: cfg_q.depot_node <= pwdata[6:0];
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (idx)
			REG_NODE_COUNT: prdata = PDATA_BITS'(cfg_q.node_count);
			REG_DEPOT_NODE: prdata = PDATA_BITS'(cfg_q.depot_node);
		endcase
	end

endmodule

// ===== rtl/core/all_pairs_shortest_path.sv =====
// Top level: request sequencer around a mirrored distance-matrix memory.
//
//  channel   | ports                                   | transfer
//  ----------+-----------------------------------------+----------------------------------
//  request   | start, busy, req                        | edge with start high, busy low
//  result    | done, res                               | edge ending the one-cycle done
//  config    | psel, penable, pwrite, paddr, pwdata,   | access cycle, pready always high
//            | prdata, pready                          |
//
// After reset the matrix is initialized by a sweep over all MAX_NODES*MAX_NODES entries
// (16384), one entry a cycle, with busy high; config transfers are taken meanwhile.
// Edge reads both entries, then writes each direction; query reads both legs, sums them
// and accumulates. With n the nodes in use, clear sweeps the n*n corner and closure relaxes
// all n*n entries per pivot: one relaxation per cycle, bounded by the matrix write port,
// except in the row setup states ST_ROW and ST_ROW_A that fetch d[i][k]. With no nodes, both skip the matrix.
// Results cannot be stalled: done pulses for one cycle as busy drops.
module all_pairs_shortest_path (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  apsp_pkg::req_t                   req,
	output logic                             done,
	output apsp_pkg::res_t                   res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [apsp_pkg::PADDR_BITS-1:0]  paddr,
	input  logic [apsp_pkg::PDATA_BITS-1:0]  pwdata,
	output logic [apsp_pkg::PDATA_BITS-1:0]  prdata,
	output logic                             pready
);
	import apsp_pkg::*;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EDGE_RD,
		ST_EDGE_W1,
		ST_EDGE_W2,
		ST_ROW,
		ST_ROW_A,
		ST_RUN,
		ST_QRY_RD,
		ST_QRY_SUM,
		ST_QRY_ACC
	} state_t;

	state_t                state_q;
	logic                  init_q;
	logic [NODE_BITS-1:0]  i_q, j_q, k_q, lim_q;
	logic [NODE_BITS-1:0]  j_s1;
	logic                  v_s1;
	logic                  last_q;
	logic [DIST_BITS-1:0]  a_q;
	logic                  ba_upd_q;
	logic [TRIP_BITS-1:0]  trip_q;
	logic                  unr_q;
	logic [TOTAL_BITS-1:0] total_q;
	req_t                  req_q;
	logic                  done_q;
	res_t                  res_q;

	cfg_t                  cfg;
	logic [CNT_BITS-1:0]   n_eff;
	logic                  accept;

	// Memory ports (both copies written alike)
	logic                  we;
	logic [ADDR_BITS-1:0]  waddr, raddr0, raddr1;
	logic [DIST_BITS-1:0]  wdata, rdata0, rdata1;

	// Request decode
	logic [NODE_BITS-1:0]  na, nb, dep;
	logic                  edge_ok, qry_ok;
	logic [DIST_BITS-1:0]  cost;

	// Relaxation datapath
	logic [DIST_BITS:0]    rx_sum;
	logic [DIST_BITS-1:0]  rx_val;
	logic                  rx_upd;

	// Query datapath
	logic                  q_unr;
	logic [TOTAL_BITS:0]   acc_sum;
	logic [TOTAL_BITS-1:0] acc_new;

	apsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apsp_ram #(.WIDTH(DIST_BITS), .DEPTH(MEM_DEPTH)) u_ram0 (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr0),
		.rdata (rdata0)
	);

	apsp_ram #(.WIDTH(DIST_BITS), .DEPTH(MEM_DEPTH)) u_ram1 (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr1),
		.rdata (rdata1)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign res    = res_q;

	// Clamp the node count to the matrix size
	assign n_eff = (32'(cfg.node_count) > 32'(MAX_NODES)) ? CNT_BITS'(MAX_NODES)
	                                                     : CNT_BITS'(cfg.node_count);

	// Decode the held request
	assign na      = NODE_BITS'(req_q.node_a);
	assign nb      = NODE_BITS'(req_q.node_b);
	assign dep     = NODE_BITS'(cfg.depot_node);
	assign edge_ok = (32'(req_q.node_a) < 32'(MAX_NODES)) && (32'(req_q.node_b) < 32'(MAX_NODES));
	assign qry_ok  = (32'(req_q.node_a) < 32'(MAX_NODES))
	              && (32'(cfg.depot_node) < 32'(MAX_NODES));
	// Masked cost stays below the unreachable code, so no clamp is needed
	assign cost    = DIST_BITS'(req_q.edge_cost & COST_MASK);

	// Relax d[i][j] through k: a_q = d[i][k], rdata0 = d[k][j], rdata1 = d[i][j]
	assign rx_sum = {1'b0, a_q} + {1'b0, rdata0};
	assign rx_val = (rx_sum >= {1'b0, DIST_INF}) ? DIST_MAX : rx_sum[DIST_BITS-1:0];
	assign rx_upd = (a_q != DIST_INF) && (rdata0 != DIST_INF) && (rdata1 > rx_val);

	// Saturating accumulate of the round trip
	assign q_unr   = !qry_ok || (rdata0 == DIST_INF) || (rdata1 == DIST_INF);
	assign acc_sum = {1'b0, total_q} + (TOTAL_BITS + 1)'(trip_q);
	assign acc_new = unr_q ? total_q
	               : (acc_sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : acc_sum[TOTAL_BITS-1:0]);

	// Drive memory addresses and writes from the sequencer state
	always_comb begin
		we     = 1'b0;
		waddr  = '0;
		wdata  = '0;
		raddr0 = '0;
		raddr1 = '0;
		unique case (state_q)
			ST_SWEEP: begin
				we    = 1'b1;
				waddr = {i_q, j_q};
				wdata = (i_q == j_q) ? '0 : DIST_INF;
			end
			ST_EDGE_RD: begin
				raddr0 = {na, nb};
				raddr1 = {nb, na};
			end
			ST_EDGE_W1: begin
				we    = edge_ok && req_q.dir_a_to_b && (rdata0 > cost);
				waddr = {na, nb};
				wdata = cost;
			end
			ST_EDGE_W2: begin
				we    = ba_upd_q;
				waddr = {nb, na};
				wdata = cost;
			end
			ST_ROW: begin
				raddr0 = {i_q, k_q};
			end
			ST_ROW_A, ST_RUN: begin
				raddr0 = {k_q, j_q};
				raddr1 = {i_q, j_q};
				we     = (state_q == ST_RUN) && v_s1 && rx_upd;
				waddr  = {i_q, j_s1};
				wdata  = rx_val;
			end
			ST_QRY_RD: begin
				raddr0 = {dep, na};
				raddr1 = {na, dep};
			end
			default: begin
			end
		endcase
	end

	// Sequencer, counters and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			init_q   <= 1'b1;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			lim_q    <= NODE_BITS'(MAX_NODES - 1);
			j_s1     <= '0;
			v_s1     <= 1'b0;
			last_q   <= 1'b0;
			a_q      <= '0;
			ba_upd_q <= 1'b0;
			trip_q   <= '0;
			unr_q    <= 1'b0;
			total_q  <= '0;
			req_q    <= '0;
			done_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_SWEEP: begin
					if (j_q == lim_q) begin
						j_q <= '0;
						if (i_q == lim_q) begin
							state_q <= ST_IDLE;
							if (init_q) begin
								init_q <= 1'b0;
							end else begin
								total_q <= '0;
								done_q  <= 1'b1;
								res_q   <= '{round_trip: '0, running_total: '0,
								             unreachable: 1'b0, done_res: 1'b1};
							end
						end else begin
							i_q <= i_q + NODE_BITS'(1);
						end
					end else begin
						j_q <= j_q + NODE_BITS'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_q <= req;
						lim_q <= NODE_BITS'(n_eff - CNT_BITS'(1));
						i_q   <= '0;
						j_q   <= '0;
						k_q   <= '0;
						v_s1  <= 1'b0;
						unique case (req.req_type)
							REQ_CLEAR: begin
								if (n_eff == '0) begin
									total_q <= '0;
									done_q  <= 1'b1;
									res_q   <= '{round_trip: '0, running_total: '0,
									             unreachable: 1'b0, done_res: 1'b1};
								end else begin
									state_q <= ST_SWEEP;
								end
							end
							REQ_EDGE: state_q <= ST_EDGE_RD;
							REQ_CLOSURE: begin
								if (n_eff == '0) begin
									done_q <= 1'b1;
									res_q  <= '{round_trip: '0, running_total: total_q,
									            unreachable: 1'b0, done_res: 1'b1};
								end else begin
									state_q <= ST_ROW;
								end
							end
							REQ_QUERY: state_q <= ST_QRY_RD;
						endcase
					end
				end
				ST_EDGE_RD: begin
					state_q <= ST_EDGE_W1;
				end
				ST_EDGE_W1: begin
					ba_upd_q <= edge_ok && req_q.dir_b_to_a && (rdata1 > cost);
					state_q  <= ST_EDGE_W2;
				end
				ST_EDGE_W2: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					res_q   <= '{round_trip: '0, running_total: total_q,
					             unreachable: 1'b0, done_res: 1'b1};
				end
				ST_ROW: begin
					state_q <= ST_ROW_A;
				end
				ST_ROW_A: begin
					// Hold d[i][k] for the row and issue column zero
					a_q     <= rdata0;
					v_s1    <= 1'b1;
					j_s1    <= j_q;
					last_q  <= (lim_q == '0);
					j_q     <= j_q + NODE_BITS'(1);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					// Issue the next column while the previous one is relaxed
					if (!last_q) begin
						v_s1   <= 1'b1;
						j_s1   <= j_q;
						last_q <= (j_q == lim_q);
						j_q    <= j_q + NODE_BITS'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					// Advance row and pivot once the last column is written
					if (v_s1 && (j_s1 == lim_q)) begin
						j_q <= '0;
						if (i_q == lim_q) begin
							i_q <= '0;
							if (k_q == lim_q) begin
								state_q <= ST_IDLE;
								done_q  <= 1'b1;
								res_q   <= '{round_trip: '0, running_total: total_q,
								             unreachable: 1'b0, done_res: 1'b1};
							end else begin
								k_q     <= k_q + NODE_BITS'(1);
								state_q <= ST_ROW;
							end
						end else begin
							i_q     <= i_q + NODE_BITS'(1);
							state_q <= ST_ROW;
						end
					end
				end
				ST_QRY_RD: begin
					state_q <= ST_QRY_SUM;
				end
				ST_QRY_SUM: begin
					unr_q   <= q_unr;
					trip_q  <= q_unr ? '0 : ({1'b0, rdata0} + {1'b0, rdata1});
					state_q <= ST_QRY_ACC;
				end
				ST_QRY_ACC: begin
					total_q <= acc_new;
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					res_q   <= '{round_trip: trip_q, running_total: acc_new,
					             unreachable: unr_q, done_res: 1'b1};
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the all-pairs shortest path block, with a matrix-level predictor.
`timescale 1ns / 100ps

module testbench;
	import apsp_pkg::*;

	localparam int GAP_MAX      = 8;
	localparam int BURST_MAX    = 10;
	localparam int RANDOM_ITEMS = 70;
	localparam int GRAPH_MAX    = 16;
	localparam int GRAPH_WIDE   = 20;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  start   = 1'b0;
	logic                  busy;
	req_t                  req     = '0;
	logic                  done;
	res_t                  res;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [PADDR_BITS-1:0] paddr   = '0;
	logic [PDATA_BITS-1:0] pwdata  = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	// Shadow copy of the matrix, the total and the two registers
	logic [DIST_BITS-1:0]  path_cost [MAX_NODES][MAX_NODES];
	logic [TOTAL_BITS-1:0] trip_total;
	logic [7:0]            nodes_cfg;
	logic [6:0]            depot_cfg;

	req_t request_backlog [$];
	res_t awaited_results [$];
	int   burst_left = 0;
	int   gap_left   = 0;
	int   mismatches = 0;

	all_pairs_shortest_path DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Reset the top-left span x span corner: zero on the diagonal, no path elsewhere
	function automatic void clear_corner(int unsigned span);
		for (int i = 0; i < span; i++)
			for (int j = 0; j < span; j++)
				path_cost[i][j] = (i == j) ? '0 : DIST_INF;
	endfunction

	// Apply one request to the shadow state and return the result it produces
	function automatic res_t apply_request(req_t r);
		res_t                   outcome;
		int unsigned            span;
		logic [DIST_BITS-1:0]   cost;
		logic [DIST_BITS-1:0]   left_leg;
		logic [DIST_BITS-1:0]   right_leg;
		logic [TRIP_BITS-1:0]   joined;
		logic [TOTAL_BITS:0]    grown;
		outcome = '0;
		outcome.done_res = 1'b1;
		span = (nodes_cfg > MAX_NODES) ? MAX_NODES : nodes_cfg;
		case (r.req_type)
			REQ_CLEAR: begin
				clear_corner(span);
				trip_total = '0;
			end
			REQ_EDGE: begin
				// Mask to the cost width and hold below the no-path code
				cost = DIST_BITS'(r.edge_cost & COST_MASK);
				if (cost >= DIST_INF)
					cost = DIST_MAX;
				if (r.dir_a_to_b && path_cost[r.node_a][r.node_b] > cost)
					path_cost[r.node_a][r.node_b] = cost;
				if (r.dir_b_to_a && path_cost[r.node_b][r.node_a] > cost)
					path_cost[r.node_b][r.node_a] = cost;
			end
			REQ_CLOSURE: begin
				// Relax in place, skipping legs with no path
				for (int k = 0; k < span; k++)
					for (int i = 0; i < span; i++)
						for (int j = 0; j < span; j++) begin
							left_leg = path_cost[i][k];
							right_leg = path_cost[k][j];
							if (left_leg != DIST_INF && right_leg != DIST_INF) begin
								joined = left_leg + right_leg;
								if (joined >= DIST_INF)
									joined = DIST_MAX;
								if (path_cost[i][j] > joined)
									path_cost[i][j] = joined[DIST_BITS-1:0];
							end
						end
			end
			REQ_QUERY: begin
				left_leg = path_cost[depot_cfg][r.node_a];
				right_leg = path_cost[r.node_a][depot_cfg];
				if (left_leg == DIST_INF || right_leg == DIST_INF) begin
					outcome.unreachable = 1'b1;
				end else begin
					joined = left_leg + right_leg;
					outcome.round_trip = joined;
					grown = trip_total + joined;
					trip_total = grown[TOTAL_BITS] ? '1 : grown[TOTAL_BITS-1:0];
				end
			end
		endcase
		outcome.running_total = trip_total;
		return outcome;
	endfunction

	function automatic void queue_request(req_type_t kind, int unsigned a, int unsigned b,
			int unsigned cost, bit ab, bit ba);
		req_t r;
		r.req_type = kind;
		r.node_a = NODE_IN_BITS'(a);
		r.node_b = NODE_IN_BITS'(b);
		r.edge_cost = EDGE_IN_BITS'(cost);
		r.dir_a_to_b = ab;
		r.dir_b_to_a = ba;
		request_backlog.push_back(r);
	endfunction

	// Mostly short edges, now and then one across the full cost range
	function automatic int unsigned random_cost();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
	endfunction

	// Hold until every request went in and every result came back
	task automatic wait_drained();
		while (request_backlog.size() != 0 || awaited_results.size() != 0 || start || busy)
			@(negedge clk);
	endtask

	// Write one register, then read it back
	task automatic write_register(logic [REG_IDX_BITS-1:0] index, int unsigned value);
		logic [PDATA_BITS-1:0] stored;
		stored = (index == REG_NODE_COUNT) ? PDATA_BITS'(value[7:0]) : PDATA_BITS'(value[6:0]);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_BITS'({index, 2'b00});
		pwdata <= PDATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		// Write transfer lands here; go straight into the read setup
		@(posedge clk);
		if (index == REG_NODE_COUNT)
			nodes_cfg = value[7:0];
		else
			depot_cfg = value[6:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== stored) begin
			$display("%0t: register %0d read back, expected %0d, got %0d",
				$time, index, stored, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic flag_field(string field, logic [TOTAL_BITS-1:0] want,
			logic [TOTAL_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Request driver: predict each accepted transfer, then offer the next in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				awaited_results.push_back(apply_request(req));
			if (start && busy) begin
				// Hold the offered request
			end else if (gap_left != 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (request_backlog.size() != 0) begin
				req <= request_backlog.pop_front();
				start <= 1'b1;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					// End of burst: draw the next one and the pause before it
					burst_left <= $urandom_range(1, BURST_MAX);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GAP_MAX);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none outstanding, expected none, got %h", $time, res);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				flag_field("round_trip", want.round_trip, res.round_trip);
				flag_field("running_total", want.running_total, res.running_total);
				flag_field("unreachable", want.unreachable, res.unreachable);
				flag_field("done_res", want.done_res, res.done_res);
			end
		end
	end

	initial begin
		int unsigned span;
		int unsigned top;
		int unsigned count;
		int unsigned a;
		int unsigned b;
		int unsigned pick;
		int          random_items;
		clear_corner(MAX_NODES);
		trip_total = '0;
		nodes_cfg = NODE_COUNT_RESET;
		depot_cfg = DEPOT_NODE_RESET;
		random_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: all 128 nodes, depot 0
		queue_request(REQ_QUERY, 0, 0, 0, 0, 0);
		queue_request(REQ_QUERY, 127, 0, 0, 0, 0);
		queue_request(REQ_EDGE, 0, 127, 16'hFFFF, 1, 1);
		queue_request(REQ_EDGE, 127, 0, 70, 1, 0);
		queue_request(REQ_EDGE, 0, 127, 0, 0, 0);
		queue_request(REQ_QUERY, 127, 0, 0, 0, 0);
		queue_request(REQ_CLEAR, 0, 0, 0, 0, 0);
		queue_request(REQ_QUERY, 127, 0, 0, 0, 0);
		wait_drained();

		// No nodes in use: clear and closure leave the matrix alone
		write_register(REG_NODE_COUNT, 0);
		write_register(REG_DEPOT_NODE, 127);
		queue_request(REQ_EDGE, 127, 1, 10, 1, 1);
		queue_request(REQ_CLEAR, 0, 0, 0, 0, 0);
		queue_request(REQ_CLOSURE, 0, 0, 0, 0, 0);
		queue_request(REQ_QUERY, 1, 0, 0, 0, 0);
		wait_drained();

		// Count above the node limit clears everything
		write_register(REG_NODE_COUNT, 255);
		queue_request(REQ_CLEAR, 0, 0, 0, 0, 0);
		queue_request(REQ_QUERY, 1, 0, 0, 0, 0);
		wait_drained();

		// One node: clear keeps entries outside its corner
		write_register(REG_NODE_COUNT, 1);
		write_register(REG_DEPOT_NODE, 0);
		queue_request(REQ_EDGE, 0, 1, 5, 1, 1);
		queue_request(REQ_CLOSURE, 0, 0, 0, 0, 0);
		queue_request(REQ_CLEAR, 0, 0, 0, 0, 0);
		queue_request(REQ_QUERY, 1, 0, 0, 0, 0);
		wait_drained();

		// Six nodes: paths through a node beyond the count are not found
		write_register(REG_NODE_COUNT, 6);
		write_register(REG_DEPOT_NODE, 2);
		queue_request(REQ_CLEAR, 0, 0, 0, 0, 0);
		queue_request(REQ_EDGE, 0, 1, 3, 1, 1);
		queue_request(REQ_EDGE, 1, 2, 4, 1, 1);
		queue_request(REQ_EDGE, 2, 9, 2, 1, 1);
		queue_request(REQ_EDGE, 9, 3, 1, 1, 1);
		queue_request(REQ_CLOSURE, 0, 0, 0, 0, 0);
		queue_request(REQ_QUERY, 0, 0, 0, 0, 0);
		queue_request(REQ_QUERY, 9, 0, 0, 0, 0);
		queue_request(REQ_QUERY, 3, 0, 0, 0, 0);
		wait_drained();

		// Random phases on small graphs
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: span = 0;
				1: span = 1;
				2: span = GRAPH_WIDE;
				default: span = $urandom_range(2, GRAPH_MAX);
			endcase
			top = (span > 1) ? span - 1 : 0;
			write_register(REG_NODE_COUNT, span);
			write_register(REG_DEPOT_NODE,
				($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, top));
			if ($urandom_range(0, 3) != 0) begin
				// Build a graph, close it, then ask for round trips
				queue_request(REQ_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
					$urandom, $urandom_range(0, 1), $urandom_range(0, 1));
				count = $urandom_range(1, span + 2);
				repeat (count) begin
					if ($urandom_range(0, 5) == 0) begin
						a = $urandom_range(0, 127);
						b = $urandom_range(0, 127);
					end else begin
						a = $urandom_range(0, top);
						b = $urandom_range(0, top);
					end
					pick = $urandom_range(1, 3);
					queue_request(REQ_EDGE, a, b, random_cost(), pick[0], pick[1]);
				end
				queue_request(REQ_CLOSURE, $urandom_range(0, 127), $urandom_range(0, 127),
					$urandom, $urandom_range(0, 1), $urandom_range(0, 1));
				pick = $urandom_range(3, 6);
				repeat (pick) begin
					a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, top);
					queue_request(REQ_QUERY, a, $urandom_range(0, 127), $urandom,
						$urandom_range(0, 1), $urandom_range(0, 1));
				end
				random_items += count + 2 + pick;
			end else begin
				// Noise: any request with any fields
				count = $urandom_range(6, 12);
				repeat (count) begin
					pick = $urandom_range(0, 3);
					queue_request(req_type_t'($urandom_range(0, 3)), $urandom_range(0, 127),
						$urandom_range(0, 127), random_cost(), pick[0], pick[1]);
				end
				random_items += count;
			end
			wait_drained();
		end

		repeat (32) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("all_pairs_shortest_path verification clean");
		end else begin
			$display("all_pairs_shortest_path verification failed");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("all_pairs_shortest_path verification failed");
		$finish;
	end

endmodule

// ===== all_pairs_shortest_path.f =====
rtl/core/apsp_pkg.sv
rtl/core/apsp_ram.sv
rtl/core/apsp_regs.sv
rtl/core/all_pairs_shortest_path.sv
sim/testbench.sv
